FILE: sv/partial_shuffle_index_sampler_defines.svh
// Assertion helpers shared by the sampler RTL.
`ifndef PARTIAL_SHUFFLE_INDEX_SAMPLER_DEFINES_SVH
`define PARTIAL_SHUFFLE_INDEX_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sampler check failed");

// Next-cycle implication, checked out of reset.
`define PSIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sampler check failed");

`endif

FILE: sv/psis_pkg.sv
`timescale 1ns / 1ps

package psis_pkg;

  localparam int unsigned REG_W = 11;
  localparam int unsigned REG_MAX = (1 << REG_W) - 1;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned RND_W = 32;
  localparam int unsigned RND_CNT_W = $clog2(RND_W);

  localparam logic [REG_W-1:0] SET_SIZE_RST = REG_W'(1024);
  localparam logic [REG_W-1:0] CHOOSE_COUNT_RST = REG_W'(1024);

  // Configuration register indexes
  localparam logic CFG_SET_SIZE = 1'b0;
  localparam logic CFG_CHOOSE_COUNT = 1'b1;

  // Input action codes
  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_INIT  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_RD_I  = 7'b0010000,
    ST_RD_J  = 7'b0100000,
    ST_WR_I  = 7'b1000000
  } state_e;

  // Status word from the serial remainder unit
  typedef struct packed {
    logic             done;
    logic [REG_W-1:0] rem;
  } rem_res_t;

endpackage

FILE: sv/partial_shuffle_index_sampler.sv
`timescale 1ns / 1ps

// Partial Fisher-Yates index sampler.
// Input: pulse start_i with action_i and random_word_i while busy_o is low;
// the word is taken at that edge. Action init rewrites the first set_size
// table entries as k -> k and returns nothing; action step emits one word.
// Config: cfg_valid_i / cfg_ready_o with cfg_index_i (0 = set_size,
// 1 = choose_count) and cfg_data_i; ready is always high, write only when idle.
// Output: done_o is high for exactly one cycle with chosen_index_o and
// last_of_round_o; the receiver cannot stall, so no backpressure exists.
// Sequence: after the edge that takes a step word, the bit-serial
// remainder unit runs, j is formed, entries i and j are read and entry i
// is written; done_o then rises, and entry j is written in the done_o
// cycle. busy_o falls in that same cycle, so the next word is taken at the
// edge that ends it at the earliest; no new word is taken while busy.
// An init word keeps busy_o high while it writes the entries, one entry
// per cycle; the next word can follow once busy_o falls.
// Reset: registers return to 1024/1024, position to 0, and a clearing pass
// writes the identity into all MAX_SET_SIZE entries, one per cycle; busy_o
// stays high until the pass ends. Config writes are taken meanwhile.
module partial_shuffle_index_sampler #(
  parameter int unsigned MAX_SET_SIZE = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             action_i,
  input  logic [psis_pkg::RND_W-1:0]       random_word_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [psis_pkg::REG_W-1:0]       cfg_data_i,
  output logic                             done_o,
  output logic [psis_pkg::IDX_W-1:0]       chosen_index_o,
  output logic                             last_of_round_o
);

`include "partial_shuffle_index_sampler_defines.svh"

  localparam int unsigned AW = $clog2(MAX_SET_SIZE);
  localparam int unsigned REG_W = psis_pkg::REG_W;
  localparam int unsigned IDX_W = psis_pkg::IDX_W;
  localparam int unsigned SIZE_CLAMP_I =
    (MAX_SET_SIZE > psis_pkg::REG_MAX) ? psis_pkg::REG_MAX : MAX_SET_SIZE;
  localparam logic [REG_W-1:0] SIZE_CLAMP = REG_W'(SIZE_CLAMP_I);
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(MAX_SET_SIZE - 1);

  // Configuration registers
  logic [REG_W-1:0] set_size_q, choose_count_q;

  // Control
  psis_pkg::state_e state_q, state_d;
  logic [REG_W-1:0] pos_q, pos_d;
  logic [AW-1:0]    sweep_q, sweep_d;
  logic             done_q, done_d;

  // Per-item payload
  logic [REG_W-1:0] i_q, i_d;
  logic [REG_W-1:0] d_q, d_d;
  logic [REG_W-1:0] j_q, j_d;
  logic [REG_W-1:0] lim_q, lim_d;
  logic             last_q, last_d;
  logic [IDX_W-1:0] vi_q, vi_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d;

  // Effective bounds
  logic [REG_W-1:0] size_eff, count_eff, i_eff;
  logic [REG_W-1:0] rem_divisor;
  logic             accept, rem_start;

  // Table memory
  logic [IDX_W-1:0] table_mem [MAX_SET_SIZE];
  logic [IDX_W-1:0] rd_q;
  logic             we;
  logic [AW-1:0]    wa, ra;
  logic [IDX_W-1:0] wd;

  psis_pkg::rem_res_t rem_res;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != psis_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign rem_start   = accept && (action_i == psis_pkg::ACT_STEP);

  // Clamp registers into their legal ranges, wrap a stale position.
  always_comb begin
    if (set_size_q == '0) begin
      size_eff = REG_W'(1);
    end else if (32'(set_size_q) > 32'(MAX_SET_SIZE)) begin
      size_eff = SIZE_CLAMP;
    end else begin
      size_eff = set_size_q;
    end
    if (choose_count_q == '0) begin
      count_eff = REG_W'(1);
    end else if (choose_count_q > size_eff) begin
      count_eff = size_eff;
    end else begin
      count_eff = choose_count_q;
    end
    i_eff = (pos_q >= count_eff) ? '0 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q     <= psis_pkg::SET_SIZE_RST;
      choose_count_q <= psis_pkg::CHOOSE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        psis_pkg::CFG_SET_SIZE:     set_size_q     <= cfg_data_i;
        psis_pkg::CFG_CHOOSE_COUNT: choose_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Divisor is taken at the accept edge, so feed it straight from the bounds.
  assign rem_divisor = size_eff - i_eff;

  psis_rem_serial u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (random_word_i),
    .divisor_i  (rem_divisor),
    .res_o      (rem_res)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    sweep_d    = sweep_q;
    done_d     = 1'b0;
    i_d        = i_q;
    d_d        = d_q;
    j_d        = j_q;
    lim_d      = lim_q;
    last_d     = last_q;
    vi_d       = vi_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    we         = 1'b0;
    wa         = sweep_q;
    wd         = IDX_W'(sweep_q);
    ra         = AW'(j_q);
    case (state_q)
      psis_pkg::ST_CLEAR: begin
        // clearing pass after reset: entry k gets k
        we      = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == LAST_ADDR) begin
          state_d = psis_pkg::ST_IDLE;
        end
      end
      psis_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            psis_pkg::ACT_INIT: begin
              sweep_d = '0;
              lim_d   = size_eff - 1'b1;
              pos_d   = '0;
              state_d = psis_pkg::ST_INIT;
            end
            psis_pkg::ACT_STEP: begin
              i_d     = i_eff;
              d_d     = size_eff - i_eff;
              last_d  = ({1'b0, i_eff} + {{REG_W{1'b0}}, 1'b1}) == {1'b0, count_eff};
              state_d = psis_pkg::ST_DIV;
            end
            default: ;
          endcase
        end
      end
      psis_pkg::ST_INIT: begin
        we      = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (32'(sweep_q) == 32'(lim_q)) begin
          state_d = psis_pkg::ST_IDLE;
        end
      end
      psis_pkg::ST_DIV: begin
        // wait on the serial remainder, then form j
        if (rem_res.done) begin
          j_d     = i_q + rem_res.rem;
          state_d = psis_pkg::ST_RD_I;
        end
      end
      psis_pkg::ST_RD_I: begin
        ra      = AW'(i_q);
        state_d = psis_pkg::ST_RD_J;
      end
      psis_pkg::ST_RD_J: begin
        // read data now holds entry i
        ra      = AW'(j_q);
        vi_d    = rd_q;
        state_d = psis_pkg::ST_WR_I;
      end
      psis_pkg::ST_WR_I: begin
        // read data holds entry j: it moves to i and goes out
        we         = 1'b1;
        wa         = AW'(i_q);
        wd         = rd_q;
        out_idx_d  = rd_q;
        out_last_d = last_q;
        done_d     = 1'b1;
        pos_d      = last_q ? '0 : (i_q + 1'b1);
        state_d    = psis_pkg::ST_IDLE;
      end
      default: begin
        state_d = psis_pkg::ST_IDLE;
      end
    endcase
    // Complete the swap in the cycle the result is shown: old entry i goes to j.
    if (done_q) begin
      we = 1'b1;
      wa = AW'(j_q);
      wd = vi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psis_pkg::ST_CLEAR;
      pos_q   <= '0;
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sweep_q <= sweep_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    d_q        <= d_d;
    j_q        <= j_d;
    lim_q      <= lim_d;
    last_q     <= last_d;
    vi_q       <= vi_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[wa] <= wd;
    end
    rd_q <= table_mem[ra];
  end

  assign done_o          = done_q;
  assign chosen_index_o  = out_idx_q;
  assign last_of_round_o = out_last_q;

  `PSIS_ASSERT_NEXT(a_step_enters_div, clk_i, rst_ni,
    rem_start, state_q == psis_pkg::ST_DIV)
  `PSIS_ASSERT_NOW(a_rem_below_divisor, clk_i, rst_ni,
    rem_res.done, rem_res.rem < d_q)
  `PSIS_ASSERT_NOW(a_swap_in_set, clk_i, rst_ni,
    state_q == psis_pkg::ST_RD_I, (j_q < size_eff) && (i_q <= j_q))
  `PSIS_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni,
    done_o, !done_o)
  `PSIS_ASSERT_NOW(a_round_end_rewinds, clk_i, rst_ni,
    done_o && last_of_round_o, pos_q == '0)

endmodule

FILE: sv/psis_rem_serial.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle, MSB first.
module psis_rem_serial (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [psis_pkg::RND_W-1:0]     dividend_i,
  input  logic [psis_pkg::REG_W-1:0]     divisor_i,
  output psis_pkg::rem_res_t             res_o
);

  logic [psis_pkg::RND_W-1:0]     dvd_q, dvd_d;
  logic [psis_pkg::REG_W:0]       rem_q, rem_d;
  logic [psis_pkg::REG_W-1:0]     dsr_q, dsr_d;
  logic [psis_pkg::RND_CNT_W-1:0] cnt_q, cnt_d;
  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [psis_pkg::REG_W:0]       trial;

  always_comb begin
    trial  = {rem_q[psis_pkg::REG_W-1:0], dvd_q[psis_pkg::RND_W-1]};
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // shift in next bit, subtract when it fits
      dvd_d = {dvd_q[psis_pkg::RND_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, dsr_q}) ? (trial - {1'b0, dsr_q}) : trial;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == psis_pkg::RND_CNT_W'(psis_pkg::RND_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q[psis_pkg::REG_W-1:0];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_SET = 1024;
  localparam int unsigned CLK_PERIOD = 10;
  // Worst init word walks every table entry once; leave some margin on top.
  localparam int unsigned SETTLE_CYCLES = MAX_SET + 16;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned DIR_ROWS = 30;
  localparam int unsigned PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 60;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  // One drawn index as it leaves the block.
  typedef struct packed {
    logic [psis_pkg::IDX_W-1:0] idx;
    logic                       last;
  } pick_t;

  // One line of the directed script: a register write or an input word,
  // optionally with the drawn index typed in by hand.
  typedef struct packed {
    row_kind_e                  kind;
    logic                       sel;
    logic [psis_pkg::REG_W-1:0] val;
    logic                       act;
    logic [psis_pkg::RND_W-1:0] rnd;
    logic                       known;
    pick_t                      typed;
  } row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start_i;
  logic                             busy_o;
  logic                             action_i;
  logic [psis_pkg::RND_W-1:0]       random_word_i;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic                             cfg_index_i;
  logic [psis_pkg::REG_W-1:0]       cfg_data_i;
  logic                             done_o;
  logic [psis_pkg::IDX_W-1:0]       chosen_index_o;
  logic                             last_of_round_o;

  // Shadow copy of the block: permutation table, round position, registers.
  logic [psis_pkg::IDX_W-1:0]       perm_tbl [MAX_SET];
  int unsigned                      draw_pos;
  logic [psis_pkg::REG_W-1:0]       size_reg;
  logic [psis_pkg::REG_W-1:0]       count_reg;

  pick_t                            pending_draws [$];
  int unsigned                      mismatch_cnt = 0;

  partial_shuffle_index_sampler #(
    .MAX_SET_SIZE(MAX_SET)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .random_word_i  (random_word_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .chosen_index_o (chosen_index_o),
    .last_of_round_o(last_of_round_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // Clamp set_size into 1..MAX_SET the way the block does.
  function automatic int unsigned active_size();
    if (size_reg == 0) begin
      return 1;
    end
    if (size_reg > MAX_SET) begin
      return MAX_SET;
    end
    return size_reg;
  endfunction

  // Rewrite the first active_size entries as the identity, restart the round.
  function automatic void reload_identity();
    int unsigned sz;
    sz = active_size();
    for (int unsigned k = 0; k < sz; k++) begin
      perm_tbl[k] = psis_pkg::IDX_W'(k);
    end
    draw_pos = 0;
  endfunction

  // One partial shuffle step: swap slot i with a random slot at or above it,
  // hand back what landed in slot i.
  function automatic pick_t draw_next(input logic [psis_pkg::RND_W-1:0] rnd);
    int unsigned                sz;
    int unsigned                n;
    int unsigned                i;
    int unsigned                j;
    logic [psis_pkg::IDX_W-1:0] held;
    pick_t                      pick;
    sz = active_size();
    n = (count_reg == 0) ? 1 : ((count_reg > sz) ? sz : count_reg);
    // A register write may have left the position past the round: start over.
    i = (draw_pos >= n) ? 0 : draw_pos;
    j = i + rnd % (sz - i);
    held = perm_tbl[i];
    perm_tbl[i] = perm_tbl[j];
    perm_tbl[j] = held;
    pick.idx = perm_tbl[i];
    pick.last = (i + 1 == n);
    draw_pos = pick.last ? 0 : i + 1;
    return pick;
  endfunction

  function automatic row_t cfg_row(input logic sel,
                                   input logic [psis_pkg::REG_W-1:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.sel = sel;
    r.val = val;
    return r;
  endfunction

  function automatic row_t word_row(input logic act,
                                    input logic [psis_pkg::RND_W-1:0] rnd);
    row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.act = act;
    r.rnd = rnd;
    return r;
  endfunction

  function automatic row_t known_row(input logic [psis_pkg::RND_W-1:0] rnd,
                                     input logic [psis_pkg::IDX_W-1:0] idx,
                                     input logic last);
    row_t r;
    r = word_row(psis_pkg::ACT_STEP, rnd);
    r.known = 1'b1;
    r.typed.idx = idx;
    r.typed.last = last;
    return r;
  endfunction

  // Offer one word and hold it until the block takes it. start_i stays high
  // on return so words can go back to back.
  task automatic send_word(input logic act, input logic [psis_pkg::RND_W-1:0] rnd,
                           input logic known, input pick_t typed);
    pick_t pick;
    cfg_valid_i <= 1'b0;
    start_i <= 1'b1;
    action_i <= act;
    random_word_i <= rnd;
    do @(posedge clk_i); while (busy_o);
    if (act == psis_pkg::ACT_STEP) begin
      pick = draw_next(rnd);
      pending_draws.push_back(known ? typed : pick);
    end else begin
      reload_identity();
    end
  endtask

  // Drop start, wait out every pending draw, then give a trailing init word
  // (which returns nothing) time to finish before touching registers.
  task automatic settle();
    start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Write one register; valid is left high so writes can go back to back.
  task automatic write_reg(input logic sel, input logic [psis_pkg::REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == psis_pkg::CFG_SET_SIZE) begin
      size_reg = val;
    end else begin
      count_reg = val;
    end
  endtask

  // Check each draw against the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    pick_t want;
    if (rst_ni && done_o) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("result with nothing pending, index", chosen_index_o, -1);
      end else begin
        want = pending_draws.pop_front();
        if (chosen_index_o !== want.idx) begin
          report_mismatch("chosen_index", chosen_index_o, want.idx);
        end
        if (last_of_round_o !== want.last) begin
          report_mismatch("last_of_round", last_of_round_o, want.last);
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    row_t                       script [DIR_ROWS];
    row_kind_e                  prev_kind;
    int unsigned                mode;
    int unsigned                gap;
    int unsigned                sz;
    int unsigned                cnt;
    logic                       act;
    logic [psis_pkg::RND_W-1:0] rnd;

    // Drive every input to a known value and hold reset.
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = psis_pkg::ACT_INIT;
    random_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = psis_pkg::CFG_SET_SIZE;
    cfg_data_i = '0;

    for (int unsigned k = 0; k < MAX_SET; k++) begin
      perm_tbl[k] = psis_pkg::IDX_W'(k);
    end
    draw_pos = 0;
    size_reg = psis_pkg::SET_SIZE_RST;
    count_reg = psis_pkg::CHOOSE_COUNT_RST;

    // Directed script. Typed-in draws are the ones obvious by inspection:
    // the first draw after reset, and draws where nothing moves: single-entry sets, or a zero word at position 0.
    script = '{
      known_row(32'h0000_0000, 10'd0, 1'b0),
      word_row(psis_pkg::ACT_STEP, 32'hFFFF_FFFF),
      word_row(psis_pkg::ACT_INIT, 32'h0000_0000),
      // set of one entry
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd1),
      known_row(32'hFFFF_FFFF, 10'd0, 1'b1),
      // zero set size acts as one
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd0),
      known_row(32'h8000_0000, 10'd0, 1'b1),
      // oversized set clamps to the table, zero count acts as one
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd2047),
      cfg_row(psis_pkg::CFG_CHOOSE_COUNT, 11'd0),
      known_row(32'h0000_0000, 10'd0, 1'b1),
      // count above the set size clamps to it: full round of four
      cfg_row(psis_pkg::CFG_CHOOSE_COUNT, 11'd2047),
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd4),
      word_row(psis_pkg::ACT_STEP, 32'd7),
      word_row(psis_pkg::ACT_STEP, 32'd3),
      word_row(psis_pkg::ACT_STEP, 32'hFFFF_FFFF),
      word_row(psis_pkg::ACT_STEP, 32'h1234_5678),
      // shrink the round under a position already past it
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd8),
      word_row(psis_pkg::ACT_STEP, 32'd5),
      word_row(psis_pkg::ACT_STEP, 32'd9),
      cfg_row(psis_pkg::CFG_CHOOSE_COUNT, 11'd2),
      word_row(psis_pkg::ACT_STEP, 32'd6),
      word_row(psis_pkg::ACT_STEP, 32'd1),
      // init over a smaller set leaves the upper entries permuted
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd4),
      word_row(psis_pkg::ACT_INIT, 32'h0000_0000),
      cfg_row(psis_pkg::CFG_SET_SIZE, 11'd8),
      cfg_row(psis_pkg::CFG_CHOOSE_COUNT, 11'd8),
      word_row(psis_pkg::ACT_STEP, 32'hA5A5_A5A5),
      word_row(psis_pkg::ACT_STEP, 32'h5A5A_5A5A),
      word_row(psis_pkg::ACT_STEP, 32'hFFFF_FFFE),
      word_row(psis_pkg::ACT_STEP, 32'd1)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing pass after reset run out before the first word.
    settle();

    prev_kind = ROW_WORD;
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        if (prev_kind == ROW_WORD) begin
          settle();
        end
        write_reg(script[r].sel, script[r].val);
      end else begin
        send_word(script[r].act, script[r].rnd, script[r].known, script[r].typed);
      end
      prev_kind = script[r].kind;
    end

    // Random phases: each starts idle with a fresh setting. Modes cycle
    // through no random gaps, sender idle most of the time, and sender idle rarely.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          sz = MAX_SET;
          cnt = MAX_SET;
        end
        1: begin
          sz = 1;
          cnt = 1;
        end
        2: begin
          sz = psis_pkg::REG_MAX;
          cnt = 0;
        end
        3: begin
          sz = 0;
          cnt = psis_pkg::REG_MAX;
        end
        default: begin
          sz = $urandom_range(2, 24);
          cnt = $urandom_range(0, sz + 3);
        end
      endcase
      mode = phase % 3;
      settle();
      write_reg(psis_pkg::CFG_SET_SIZE, psis_pkg::REG_W'(sz));
      write_reg(psis_pkg::CFG_CHOOSE_COUNT, psis_pkg::REG_W'(cnt));

      for (int unsigned w = 0; w < WORDS_PER_PHASE; w++) begin
        // Now and then stop mid-round and move the round length.
        if ($urandom_range(99) < 3) begin
          settle();
          write_reg(psis_pkg::CFG_CHOOSE_COUNT,
                    psis_pkg::REG_W'($urandom_range(0, active_size() + 2)));
        end
        act = ($urandom_range(99) < 8) ? psis_pkg::ACT_INIT : psis_pkg::ACT_STEP;
        case ($urandom_range(7))
          0: begin
            rnd = '0;
          end
          1: begin
            rnd = '1;
          end
          2: begin
            rnd = psis_pkg::RND_W'($urandom_range(63));
          end
          default: begin
            rnd = $urandom();
          end
        endcase
        send_word(act, rnd, 1'b0, '0);

        // Hold the sender back: either until every draw is home, or for a
        // random gap so the next start lands on any cycle of the work.
        if ($urandom_range(99) < 3) begin
          start_i <= 1'b0;
          do @(posedge clk_i); while (pending_draws.size() != 0);
        end else begin
          gap = 0;
          if (mode == 1 && $urandom_range(99) < 70) begin
            gap = $urandom_range(1, 60);
          end else if (mode == 2 && $urandom_range(99) < 9) begin
            gap = $urandom_range(1, 60);
          end
          if (gap > 0) begin
            start_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end

    // Drain every outstanding draw plus the tail of any init word.
    settle();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/psis_pkg.sv
sv/psis_rem_serial.sv
sv/partial_shuffle_index_sampler.sv
tb/tb.sv
